/* rtl/core/bpdr_pkg.sv */
package bpdr_pkg;

    localparam int ACC_W   = 32;
    localparam int FI_W    = 20;
    localparam int PIX_W   = 8;
    localparam int THR_W   = 7;
    localparam int NF_W    = 7;
    localparam int FT_W    = 20;
    localparam int DIST_W  = 32;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 2;
    localparam int T10_W   = 11;
    localparam int K_W     = 10;
    localparam int PROD_W  = ACC_W + T10_W;

    localparam logic [T10_W-1:0] THR_SCALE    = T10_W'(10);
    localparam logic [T10_W-1:0] THR10_RESET  = T10_W'(100);
    localparam logic [NF_W-1:0]  NF_RESET     = NF_W'(5);
    localparam logic [FT_W-1:0]  FT_RESET     = '1;
    localparam logic [K_W-1:0]   K_NORM       = K_W'(1000);
    localparam logic [K_W-1:0]   K_NORM_BONUS = K_W'(700);
    localparam logic [K_W-1:0]   K_RAW        = K_W'(10);
    localparam logic [K_W-1:0]   K_RAW_BONUS  = K_W'(7);
    localparam logic [FI_W-1:0]  REPEAT_GAP   = FI_W'(1);
    localparam logic [FI_W-1:0]  BONUS_GAP    = FI_W'(5);
    localparam logic [FI_W-1:0]  TAIL_FRAMES  = FI_W'(2);
    localparam logic [ACC_W-1:0] NORM_MIN     = ACC_W'(1);

    typedef logic [ACC_W-1:0]  t_acc;
    typedef logic [PROD_W-1:0] t_prod;

    typedef enum logic [1:0] {
        ACT_PASS    = 2'd0,
        ACT_RESTORE = 2'd1,
        ACT_REPEAT  = 2'd2
    } t_action;

    typedef enum logic [CIDX_W-1:0] {
        CFG_THRESH = 2'd0,
        CFG_NOISE  = 2'd1,
        CFG_TOTAL  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_prev;
        logic [PIX_W-1:0] pixel_cur;
        logic [PIX_W-1:0] pixel_next;
        logic [PIX_W-1:0] pixel_next2;
        logic             is_luma;
        logic             last_of_frame;
        logic [FI_W-1:0]  frame_index;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0]  restored_pixel;
        logic              frame_done;
        t_action           frame_action;
        logic [DIST_W-1:0] dist_prev_sum;
        logic [DIST_W-1:0] dist_next_sum;
    } t_out;

    typedef struct packed {
        logic            vld;
        logic [FI_W-1:0] frame;
    } t_rmv;

    typedef struct packed {
        logic [PIX_W-1:0] restored;
        logic             last;
        logic             dec;
        t_action          act;
        logic             bonus;
        logic [FI_W-1:0]  fi;
        t_acc             dist_cur;
        t_acc             dist_next;
        t_acc             mot_prev;
        t_acc             mot_next;
    } t_s2;

    typedef struct packed {
        logic [PIX_W-1:0]  restored;
        logic              last;
        logic              dec;
        t_action           act;
        logic [FI_W-1:0]   fi;
        logic [DIST_W-1:0] dp;
        logic [DIST_W-1:0] dn;
        logic              norm;
        t_prod             a_cur;
        t_prod             a_next;
        t_prod             b_prev;
        t_prod             b_next;
    } t_s3;

endpackage

/* rtl/core/bpdr_front.sv */
module bpdr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  bpdr_pkg::t_in               i_item,
    input  logic                        i_adv,
    input  logic [bpdr_pkg::NF_W-1:0]   i_noise,
    input  logic [bpdr_pkg::FT_W-1:0]   i_total,
    input  bpdr_pkg::t_rmv              i_rmv,
    output bpdr_pkg::t_s2               o_s2
);
    import bpdr_pkg::*;

    localparam int CMP_W = (FI_W + 1 > FT_W) ? FI_W + 1 : FT_W;

    t_in   r_in;
    t_s2   r_s2;
    t_s2   n_s2;
    t_acc  r_rc, r_rn, r_mp, r_mn;
    t_acc  n_rc, n_rn, n_mp, n_mn;
    t_acc  x_rc, x_rn, x_mp, x_mn;

    logic [PIX_W+1:0] pos, neg, dif;
    logic [PIX_W:0]   half, sum_p, sum_nn;
    logic [PIX_W-1:0] rest, avg_p, avg_nn;
    logic [CMP_W-1:0] fi_tail;
    logic             boundary, repeat_fr, evaluated;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_acc acc_add(input t_acc acc, input logic [PIX_W-1:0] d,
                                     input logic [NF_W-1:0] nf);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W + 1)'(d);
        if (d > PIX_W'(nf)) begin
            return s[ACC_W] ? '1 : s[ACC_W-1:0];
        end
        return acc;
    endfunction

    always_comb begin
        pos  = (PIX_W + 2)'({r_in.pixel_cur, 1'b0}) + (PIX_W + 2)'({r_in.pixel_next, 1'b0});
        neg  = (PIX_W + 2)'(r_in.pixel_prev) + (PIX_W + 2)'(r_in.pixel_next2);
        dif  = pos - neg;
        half = dif[PIX_W+1:1];
        if (pos <= neg) begin
            rest = '0;
        end else if (half[PIX_W]) begin
            rest = '1;
        end else begin
            rest = half[PIX_W-1:0];
        end
        sum_p  = (PIX_W + 1)'(r_in.pixel_prev) + (PIX_W + 1)'(rest);
        sum_nn = (PIX_W + 1)'(r_in.pixel_next2) + (PIX_W + 1)'(rest);
        avg_p  = sum_p[PIX_W:1];
        avg_nn = sum_nn[PIX_W:1];

        fi_tail   = CMP_W'(r_in.frame_index) + CMP_W'(TAIL_FRAMES);
        boundary  = (r_in.frame_index == '0) || (fi_tail >= CMP_W'(i_total));
        repeat_fr = !boundary && i_rmv.vld
                    && (r_in.frame_index == i_rmv.frame + REPEAT_GAP);
        evaluated = !boundary && !repeat_fr;

        x_rc = r_rc;
        x_rn = r_rn;
        x_mp = r_mp;
        x_mn = r_mn;
        if (evaluated && r_in.is_luma) begin
            x_rc = acc_add(r_rc, absdiff(avg_p, r_in.pixel_cur), i_noise);
            x_rn = acc_add(r_rn, absdiff(avg_nn, r_in.pixel_next), i_noise);
            x_mp = acc_add(r_mp, absdiff(r_in.pixel_cur, r_in.pixel_prev), i_noise);
            x_mn = acc_add(r_mn, absdiff(r_in.pixel_cur, r_in.pixel_next), i_noise);
        end

        n_rc = r_in.last_of_frame ? '0 : x_rc;
        n_rn = r_in.last_of_frame ? '0 : x_rn;
        n_mp = r_in.last_of_frame ? '0 : x_mp;
        n_mn = r_in.last_of_frame ? '0 : x_mn;

        n_s2.restored  = rest;
        n_s2.last      = r_in.last_of_frame;
        n_s2.dec       = r_in.last_of_frame && evaluated;
        n_s2.act       = repeat_fr ? ACT_REPEAT : ACT_PASS;
        n_s2.bonus     = i_rmv.vld && (r_in.frame_index == i_rmv.frame + BONUS_GAP);
        n_s2.fi        = r_in.frame_index;
        n_s2.dist_cur  = r_in.last_of_frame ? x_rc : '0;
        n_s2.dist_next = r_in.last_of_frame ? x_rn : '0;
        n_s2.mot_prev  = r_in.last_of_frame ? x_mp : '0;
        n_s2.mot_next  = r_in.last_of_frame ? x_mn : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= '0;
            r_rn <= '0;
            r_mp <= '0;
            r_mn <= '0;
        end else if (i_adv) begin
            r_rc <= n_rc;
            r_rn <= n_rn;
            r_mp <= n_mp;
            r_mn <= n_mn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_item;
        end
        if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

/* rtl/core/bpdr_scale.sv */
module bpdr_scale (
    input  logic                         i_clk,
    input  logic                         i_adv,
    input  bpdr_pkg::t_s2                i_s2,
    input  logic [bpdr_pkg::T10_W-1:0]   i_thr10,
    output bpdr_pkg::t_s3                o_s3
);
    import bpdr_pkg::*;

    localparam logic [63:0] DIST_MAX = 64'hFFFF_FFFF;

    t_s3             r_s3;
    t_s3             n_s3;
    logic [K_W-1:0]  k;
    logic            norm;

    function automatic logic [DIST_W-1:0] dist_sat(input t_acc a);
        return (64'(a) > DIST_MAX) ? '1 : DIST_W'(a);
    endfunction

    always_comb begin
        norm = (i_s2.mot_prev > NORM_MIN) && (i_s2.mot_next > NORM_MIN);
        if (norm) begin
            k = i_s2.bonus ? K_NORM_BONUS : K_NORM;
        end else begin
            k = i_s2.bonus ? K_RAW_BONUS : K_RAW;
        end
        n_s3.restored = i_s2.restored;
        n_s3.last     = i_s2.last;
        n_s3.dec      = i_s2.dec;
        n_s3.act      = i_s2.act;
        n_s3.fi       = i_s2.fi;
        n_s3.dp       = dist_sat(i_s2.dist_cur);
        n_s3.dn       = dist_sat(i_s2.dist_next);
        n_s3.norm     = norm;
        n_s3.a_cur    = t_prod'(i_s2.dist_cur) * t_prod'(k);
        n_s3.a_next   = t_prod'(i_s2.dist_next) * t_prod'(k);
        n_s3.b_prev   = t_prod'(i_s2.mot_prev) * t_prod'(i_thr10);
        n_s3.b_next   = t_prod'(i_s2.mot_next) * t_prod'(i_thr10);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

/* rtl/core/bpdr_decide.sv */
module bpdr_decide (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  bpdr_pkg::t_s3                i_s3,
    input  logic [bpdr_pkg::T10_W-1:0]   i_thr10,
    output bpdr_pkg::t_rmv               o_rmv,
    output bpdr_pkg::t_out               o_item
);
    import bpdr_pkg::*;

    t_rmv    r_rmv;
    t_out    r_out;
    t_out    n_out;
    logic    below;
    t_prod   t10;

    always_comb begin
        t10 = t_prod'(i_thr10);
        if (i_s3.norm) begin
            below = (i_s3.a_cur < i_s3.b_prev) && (i_s3.a_cur < i_s3.b_next)
                    && (i_s3.a_next < i_s3.b_prev) && (i_s3.a_next < i_s3.b_next);
        end else begin
            below = (i_s3.a_cur < t10) && (i_s3.a_next < t10);
        end
        n_out.restored_pixel = i_s3.restored;
        n_out.frame_done     = i_s3.last;
        n_out.dist_prev_sum  = i_s3.dp;
        n_out.dist_next_sum  = i_s3.dn;
        if (!i_s3.last) begin
            n_out.frame_action = ACT_PASS;
        end else if (i_s3.dec) begin
            n_out.frame_action = below ? ACT_RESTORE : ACT_PASS;
        end else begin
            n_out.frame_action = i_s3.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmv <= '0;
        end else if (i_adv && i_s3.dec && below) begin
            r_rmv.vld   <= 1'b1;
            r_rmv.frame <= i_s3.fi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rmv  = r_rmv;
    assign o_item = r_out;

endmodule

/* rtl/core/blend_pulldown_detect_restore.sv */
// Restores blended pulldown frames from a stream of co-located pixels of four frames and
// reports, on the last pixel of each frame, whether that frame should be replaced. Items pass
// through four registered stages (input, accumulation, multiplication, decision and output),
// and one item is taken per clock while the output is not held back by i_ready.
// The exception is the end of an evaluated frame: the next item waits in the input register
// until the decision on the frame has updated the record of the last removed frame.
// Configuration writes are taken at once and should only be made while the block is empty.
module blend_pulldown_detect_restore (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  bpdr_pkg::t_in                    i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output bpdr_pkg::t_out                   o_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bpdr_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [bpdr_pkg::CFG_W-1:0]       i_cfg_data
);
    import bpdr_pkg::*;

    logic [T10_W-1:0] r_thr10, n_thr10;
    logic [NF_W-1:0]  r_noise, n_noise;
    logic [FT_W-1:0]  r_total, n_total;

    logic r_v1, r_v2, r_v3, r_ov;
    logic adv1, adv2, adv3, free_out, free3, free2, hazard, load;

    t_s2  s2;
    t_s3  s3;
    t_rmv rmv;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_thr10 = r_thr10;
        n_noise = r_noise;
        n_total = r_total;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESH: n_thr10 = T10_W'(i_cfg_data[THR_W-1:0]) * THR_SCALE;
                CFG_NOISE:  n_noise = i_cfg_data[NF_W-1:0];
                CFG_TOTAL:  n_total = i_cfg_data[FT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        free_out = !r_ov || i_ready;
        adv3     = r_v3 && free_out;
        free3    = !r_v3 || adv3;
        adv2     = r_v2 && free3;
        free2    = !r_v2 || adv2;
        hazard   = (r_v2 && s2.dec) || (r_v3 && s3.dec);
        adv1     = r_v1 && free2 && !hazard;
        o_ready  = !r_v1 || adv1;
        load     = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr10 <= THR10_RESET;
            r_noise <= NF_RESET;
            r_total <= FT_RESET;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_thr10 <= n_thr10;
            r_noise <= n_noise;
            r_total <= n_total;
            if (load) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (adv3) begin
                r_v3 <= 1'b0;
            end
            if (adv3) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    bpdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (i_item),
        .i_adv   (adv1),
        .i_noise (r_noise),
        .i_total (r_total),
        .i_rmv   (rmv),
        .o_s2    (s2)
    );

    bpdr_scale u_scale (
        .i_clk   (i_clk),
        .i_adv   (adv2),
        .i_s2    (s2),
        .i_thr10 (r_thr10),
        .o_s3    (s3)
    );

    bpdr_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv3),
        .i_s3    (s3),
        .i_thr10 (r_thr10),
        .o_rmv   (rmv),
        .o_item  (o_item)
    );

    assign o_valid = r_ov;

    a_action_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.frame_action != ACT_PASS) |-> o_item.frame_done)
        else $error("frame action reported on a pixel that does not end a frame");

    a_sums_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.frame_done |->
            (o_item.dist_prev_sum == '0) && (o_item.dist_next_sum == '0))
        else $error("distance sums reported on a pixel that does not end a frame");

    a_one_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v2 && s2.dec && r_v3 && s3.dec))
        else $error("two frame decisions in flight at once");

endmodule

/* dv/pulldown_restore_checker.sv */
module pulldown_restore_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          px_valid,
    input  logic                          px_ready,
    input  bpdr_pkg::t_in                 px_item,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  bpdr_pkg::t_out                res_item,
    input  logic                          reg_valid,
    input  logic                          reg_ready,
    input  logic [bpdr_pkg::CIDX_W-1:0]   reg_index,
    input  logic [bpdr_pkg::CFG_W-1:0]    reg_data,
    output int                            pending,
    output int                            mismatches,
    output int                            restores,
    output int                            repeats
);
    import bpdr_pkg::*;

    localparam logic [THR_W-1:0] THRESH_AT_RESET = THR_W'(10);

    logic [THR_W-1:0] thr_cfg;
    logic [NF_W-1:0]  floor_cfg;
    logic [FT_W-1:0]  total_cfg;

    logic [ACC_W-1:0] sum_reblend_cur;
    logic [ACC_W-1:0] sum_reblend_next;
    logic [ACC_W-1:0] sum_motion_prev;
    logic [ACC_W-1:0] sum_motion_next;
    logic [FI_W-1:0]  last_removed;
    logic             removed_seen;

    t_out awaited_results[$];
    t_out want;
    int   waiting = 0;
    int   mismatch_count = 0;
    int   restore_count = 0;
    int   repeat_count = 0;

    assign pending    = waiting;
    assign mismatches = mismatch_count;
    assign restores   = restore_count;
    assign repeats    = repeat_count;

    function automatic logic [ACC_W-1:0] floored_add(input logic [ACC_W-1:0] acc,
                                                     input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        logic [ACC_W:0]   s;
        d = (a > b) ? a - b : b - a;
        if (d <= PIX_W'(floor_cfg)) return acc;
        s = {1'b0, acc} + (ACC_W + 1)'(d);
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    // Cross-multiplied d*100/m*k/10 < threshold, or d*k/10 if not norm.
    function automatic bit under_threshold(input logic [ACC_W-1:0] distance,
                                           input logic [ACC_W-1:0] m,
                                           input bit norm, input bit bonus);
        logic [63:0] k;
        logic [63:0] lhs;
        logic [63:0] rhs;
        k = bonus ? 64'd7 : 64'd10;
        if (norm) begin
            lhs = 64'(distance) * 64'd100 * k;
            rhs = 64'(thr_cfg) * 64'(m) * 64'd10;
        end else begin
            lhs = 64'(distance) * k;
            rhs = 64'(thr_cfg) * 64'd10;
        end
        return lhs < rhs;
    endfunction

    function automatic t_out predict_restored_item(input t_in it);
        t_out             res;
        logic [PIX_W+1:0] gain;
        logic [PIX_W+1:0] loss;
        logic [PIX_W:0]   half;
        logic [PIX_W:0]   pair;
        logic [PIX_W-1:0] rp;
        logic [PIX_W-1:0] reblend_p;
        logic [PIX_W-1:0] reblend_nn;
        logic [FI_W:0]    fi_plus;
        logic [FI_W-1:0]  after_removed;
        logic [FI_W-1:0]  bonus_frame;
        logic [ACC_W-1:0] m;
        bit               at_boundary;
        bit               is_repeat;
        bit               norm;
        bit               bonus;

        gain = (PIX_W + 2)'({it.pixel_cur, 1'b0}) + (PIX_W + 2)'({it.pixel_next, 1'b0});
        loss = (PIX_W + 2)'(it.pixel_prev) + (PIX_W + 2)'(it.pixel_next2);
        half = (gain > loss) ? (PIX_W + 1)'((gain - loss) >> 1) : '0;
        rp = (half > 9'd255) ? 8'hFF : half[PIX_W-1:0];
        pair = (PIX_W + 1)'(it.pixel_prev) + (PIX_W + 1)'(rp);
        reblend_p = pair[PIX_W:1];
        pair = (PIX_W + 1)'(it.pixel_next2) + (PIX_W + 1)'(rp);
        reblend_nn = pair[PIX_W:1];

        fi_plus = {1'b0, it.frame_index} + {1'b0, TAIL_FRAMES};
        after_removed = last_removed + REPEAT_GAP;
        bonus_frame = last_removed + BONUS_GAP;
        at_boundary = (it.frame_index == '0) || (fi_plus >= {1'b0, total_cfg});
        is_repeat = !at_boundary && removed_seen && (it.frame_index == after_removed);

        if (!at_boundary && !is_repeat && it.is_luma) begin
            sum_reblend_cur  = floored_add(sum_reblend_cur, reblend_p, it.pixel_cur);
            sum_reblend_next = floored_add(sum_reblend_next, reblend_nn, it.pixel_next);
            sum_motion_prev  = floored_add(sum_motion_prev, it.pixel_cur, it.pixel_prev);
            sum_motion_next  = floored_add(sum_motion_next, it.pixel_cur, it.pixel_next);
        end

        res = '0;
        res.restored_pixel = rp;
        res.frame_done = it.last_of_frame;
        res.frame_action = ACT_PASS;
        if (it.last_of_frame) begin
            if (is_repeat) begin
                res.frame_action = ACT_REPEAT;
            end else if (!at_boundary) begin
                m = (sum_motion_prev < sum_motion_next) ? sum_motion_prev : sum_motion_next;
                norm = (sum_motion_prev > 1) && (sum_motion_next > 1);
                bonus = removed_seen && (it.frame_index == bonus_frame);
                if (under_threshold(sum_reblend_next, m, norm, bonus) &&
                    under_threshold(sum_reblend_cur, m, norm, bonus)) begin
                    res.frame_action = ACT_RESTORE;
                    last_removed = it.frame_index;
                    removed_seen = 1'b1;
                end
            end
            res.dist_prev_sum = sum_reblend_cur;
            res.dist_next_sum = sum_reblend_next;
            sum_reblend_cur  = '0;
            sum_reblend_next = '0;
            sum_motion_prev  = '0;
            sum_motion_next  = '0;
        end
        return res;
    endfunction

    task automatic check_result(input t_out exp_item, input t_out got);
        if (got.restored_pixel !== exp_item.restored_pixel) begin
            $error("restored_pixel: expected %0d, actual %0d",
                   exp_item.restored_pixel, got.restored_pixel);
            mismatch_count++;
        end
        if (got.frame_done !== exp_item.frame_done) begin
            $error("frame_done: expected %0d, actual %0d", exp_item.frame_done, got.frame_done);
            mismatch_count++;
        end
        if (got.frame_action !== exp_item.frame_action) begin
            $error("frame_action: expected %0d, actual %0d",
                   exp_item.frame_action, got.frame_action);
            mismatch_count++;
        end
        if (got.dist_prev_sum !== exp_item.dist_prev_sum) begin
            $error("dist_prev_sum: expected %0d, actual %0d",
                   exp_item.dist_prev_sum, got.dist_prev_sum);
            mismatch_count++;
        end
        if (got.dist_next_sum !== exp_item.dist_next_sum) begin
            $error("dist_next_sum: expected %0d, actual %0d",
                   exp_item.dist_next_sum, got.dist_next_sum);
            mismatch_count++;
        end
        if (exp_item.frame_action == ACT_RESTORE) restore_count++;
        if (exp_item.frame_action == ACT_REPEAT) repeat_count++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            thr_cfg          = THRESH_AT_RESET;
            floor_cfg        = NF_RESET;
            total_cfg        = FT_RESET;
            sum_reblend_cur  = '0;
            sum_reblend_next = '0;
            sum_motion_prev  = '0;
            sum_motion_next  = '0;
            last_removed     = '0;
            removed_seen     = 1'b0;
            awaited_results.delete();
        end else begin
            if (res_valid && res_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("Result item arrived with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_result(want, res_item);
                end
            end
            if (px_valid && px_ready) begin
                awaited_results.push_back(predict_restored_item(px_item));
            end
            if (reg_valid && reg_ready) begin
                case (reg_index)
                    CFG_THRESH: thr_cfg = reg_data[THR_W-1:0];
                    CFG_NOISE:  floor_cfg = reg_data[NF_W-1:0];
                    CFG_TOTAL:  total_cfg = reg_data[FT_W-1:0];
                    default: ;
                endcase
            end
        end
        waiting = awaited_results.size();
    end

endmodule

/* dv/blend_pulldown_detect_restore_tb.sv */
module blend_pulldown_detect_restore_tb;
    import bpdr_pkg::*;

    typedef enum int {
        FR_BLEND,
        FR_NEAR,
        FR_NOISE,
        FR_FLAT
    } t_frame_kind;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 195;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              px_valid;
    logic              px_ready;
    t_in               px_item;
    logic              res_valid;
    logic              res_ready;
    t_out              res_item;
    logic              reg_valid;
    logic              reg_ready;
    logic [CIDX_W-1:0] reg_index;
    logic [CFG_W-1:0]  reg_data;

    logic px_taken = 1'b0;
    logic reg_taken = 1'b0;
    bit   tx_quiet = 1'b0;
    int   pending;
    int   mismatches;
    int   restores;
    int   repeats;
    int   pixel_count = 0;
    int   frame_count = 0;
    int   setting_count = 0;

    always #6 clk = ~clk;

    blend_pulldown_detect_restore i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (px_valid),
        .o_ready     (px_ready),
        .i_item      (px_item),
        .o_valid     (res_valid),
        .i_ready     (res_ready),
        .o_item      (res_item),
        .i_cfg_valid (reg_valid),
        .o_cfg_ready (reg_ready),
        .i_cfg_index (reg_index),
        .i_cfg_data  (reg_data)
    );

    pulldown_restore_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .px_valid   (px_valid),
        .px_ready   (px_ready),
        .px_item    (px_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item),
        .reg_valid  (reg_valid),
        .reg_ready  (reg_ready),
        .reg_index  (reg_index),
        .reg_data   (reg_data),
        .pending    (pending),
        .mismatches (mismatches),
        .restores   (restores),
        .repeats    (repeats)
    );

    always @(posedge clk) begin
        px_taken  <= px_valid && px_ready;
        reg_taken <= reg_valid && reg_ready;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [PIX_W-1:0] nudge(input int v);
        int s;
        s = v + int'($urandom_range(0, 12)) - 6;
        if (s < 0) s = 0;
        if (s > 255) s = 255;
        return s[PIX_W-1:0];
    endfunction

    // A blended frame is built from three clean frames a, b, c: the current frame mixes a
    // with b and the next frame mixes b with c, so that b can be recovered to within one.
    function automatic t_in make_pixel(input t_frame_kind kind);
        t_in px;
        int  a;
        int  b;
        int  c;
        int  lvl;
        px = '0;
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
        case (kind)
            FR_BLEND, FR_NEAR: begin
                px.pixel_prev  = PIX_W'(a);
                px.pixel_cur   = PIX_W'((a + b) / 2);
                px.pixel_next  = PIX_W'((b + c) / 2);
                px.pixel_next2 = PIX_W'(c);
                if (kind == FR_NEAR) begin
                    px.pixel_cur  = nudge(int'(px.pixel_cur));
                    px.pixel_next = nudge(int'(px.pixel_next));
                end
            end
            FR_NOISE: begin
                px.pixel_prev  = PIX_W'($urandom_range(0, 255));
                px.pixel_cur   = PIX_W'($urandom_range(0, 255));
                px.pixel_next  = PIX_W'($urandom_range(0, 255));
                px.pixel_next2 = PIX_W'($urandom_range(0, 255));
            end
            default: begin
                lvl = $urandom_range(0, 252);
                px.pixel_prev  = PIX_W'(lvl + int'($urandom_range(0, 3)));
                px.pixel_cur   = PIX_W'(lvl + int'($urandom_range(0, 3)));
                px.pixel_next  = PIX_W'(lvl + int'($urandom_range(0, 3)));
                px.pixel_next2 = PIX_W'(lvl + int'($urandom_range(0, 3)));
            end
        endcase
        return px;
    endfunction

    task automatic send_pixel(input t_in px);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
        repeat (gap) @(negedge clk);
        px_item = px;
        px_valid = 1'b1;
        do @(negedge clk); while (!px_taken);
        px_valid = 1'b0;
        pixel_count++;
    endtask

    task automatic send_frame(input t_frame_kind kind, input logic [FI_W-1:0] fi,
                              input int npix);
        t_in px;
        for (int i = 0; i < npix; i++) begin
            px = make_pixel(kind);
            px.is_luma = ($urandom_range(0, 99) >= 15);
            px.last_of_frame = (i == npix - 1);
            px.frame_index = fi;
            send_pixel(px);
        end
        frame_count++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        reg_index = idx;
        reg_data = value;
        reg_valid = 1'b1;
        do @(negedge clk); while (!reg_taken);
        reg_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial begin
        bit ready_quiet;
        int stall;
        res_ready = 1'b0;
        ready_quiet = 1'b0;
        stall = 0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0) ready_quiet = !ready_quiet;
            if (ready_quiet) begin
                res_ready = 1'b1;
            end else if (stall > 0) begin
                res_ready = 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                res_ready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [FI_W-1:0]  fi;
        logic [THR_W-1:0] thr;
        logic [NF_W-1:0]  nf;
        logic [FT_W-1:0]  ftot;
        int               sent;
        int               roll;
        int               npix;
        t_frame_kind      kind;

        rst_n = 1'b0;
        px_valid = 1'b0;
        px_item = '0;
        reg_valid = 1'b0;
        reg_index = CFG_THRESH;
        reg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send_pixel('{8'd255, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0, 20'd0});
        send_pixel('{8'd0, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, 20'd0});
        send_frame(FR_BLEND, 20'd1, 5);
        send_frame(FR_BLEND, 20'd2, 2);
        wait_for_results();
        send_frame(FR_NOISE, 20'd3, 2);
        send_frame(FR_NOISE, 20'd4, 2);
        send_frame(FR_NEAR, 20'd6, 3);
        send_frame(FR_FLAT, 20'd9, 2);
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 20'hFFFFD});
        send_pixel('{8'd0, 8'd128, 8'd127, 8'd1, 1'b0, 1'b1, 20'hFFFFF});
        send_frame(FR_BLEND, 20'hFFFFC, 2);
        wait_for_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    thr = 7'd2;
                    nf = 7'd2;
                    ftot = FT_RESET;
                end
                1: begin
                    thr = 7'd99;
                    nf = 7'd99;
                    ftot = FT_W'($urandom_range(100000, 1048575));
                end
                2: begin
                    thr = '1;
                    nf = '0;
                    ftot = 20'd40;
                end
                3: begin
                    thr = '0;
                    nf = '1;
                    ftot = '0;
                end
                4: begin
                    thr = 7'd10;
                    nf = 7'd5;
                    ftot = 20'd1;
                end
                default: begin
                    thr = THR_W'($urandom_range(2, 99));
                    nf = ($urandom_range(0, 3) == 0) ? NF_W'($urandom_range(2, 99))
                                                     : NF_W'($urandom_range(2, 20));
                    roll = $urandom_range(0, 3);
                    if (roll < 2) ftot = FT_RESET;
                    else if (roll == 2) ftot = FT_W'($urandom_range(3, 60));
                    else ftot = FT_W'($urandom);
                end
            endcase
            write_reg(CFG_THRESH, CFG_W'(thr));
            write_reg(CFG_NOISE, CFG_W'(nf));
            write_reg(CFG_TOTAL, CFG_W'(ftot));
            setting_count++;

            if (ftot < 64) begin
                fi = FI_W'($urandom_range(0, 70));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 30) fi = '0;
                else if (roll < 70) fi = FI_W'($urandom_range(1, 2000));
                else fi = FI_W'($urandom);
            end

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) kind = FR_BLEND;
                else if (roll < 65) kind = FR_NEAR;
                else if (roll < 85) kind = FR_NOISE;
                else kind = FR_FLAT;
                npix = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                                   : $urandom_range(13, 40);
                send_frame(kind, fi, npix);
                sent += npix;

                roll = $urandom_range(0, 99);
                if (roll < 85) fi = fi + FI_W'(1);
                else if (roll < 95) fi = fi + FI_W'($urandom_range(2, 6));
                else if (ftot < 64) fi = FI_W'($urandom_range(0, 70));
                else fi = FI_W'($urandom);

                if ($urandom_range(0, 99) < 3) wait_for_results();
            end
            wait_for_results();
        end

        $display("Sent %0d pixels in %0d frames under %0d register settings after the reset one.",
                 pixel_count, frame_count, setting_count);
        $display("Frames restored: %0d, frames repeated: %0d, mismatches: %0d.",
                 restores, repeats, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
